[rtl/lrt_pkg.sv]
// Package for the learned route table: request types, route kind codes,
// register indexes and shared constants. No dependencies.
package lrt_pkg;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned CHAN_W  = 4;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned ID_W    = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_SELF         = 3'd0;
    localparam logic [KIND_W-1:0] KIND_LOCAL        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GATEWAY      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BROADCAST    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GATEWAY_SELF = 3'd4;
    localparam logic [KIND_W-1:0] KIND_INVALID      = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_HOST    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATEWAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK    = 2'd2;

    localparam logic [ADDR_W-1:0] MASK_RESET   = 32'hFFFF_FF00;
    localparam logic [ID_W-1:0]   ID_NETWORK   = 8'h00;
    localparam logic [ID_W-1:0]   ID_BROADCAST = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_NONE    = 4'h0;

    typedef struct packed {
        logic              action;
        logic [CHAN_W-1:0] arrival_channel;
        logic [ADDR_W-1:0] source_address;
        logic [ADDR_W-1:0] dest_address;
    } t_in_req;

    typedef struct packed {
        logic [KIND_W-1:0] route_kind;
        logic [CHAN_W-1:0] out_channel;
    } t_out_req;

    // decode result handed from the classifier to the pipeline
    typedef struct packed {
        logic              learn_en;
        logic              lookup;
        logic [KIND_W-1:0] kind;
    } t_cls;

endpackage

[rtl/learned_route_table_core.sv]
// Learned route table: learns source channels and routes each request's destination.
// Each accepted request passes a stage-1 register, then the output register; one request per cycle
// while the result side takes results, set by the single table RAM read port.
// Reset clears config to defaults and all table valid bits together; no sweep.
// Depends on lrt_pkg, lrt_classify, lrt_ram.
module learned_route_table_core #(
    parameter int unsigned TABLE_ENTRIES = 254
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lrt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lrt_pkg::ADDR_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lrt_pkg::t_in_req                i_in_req,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lrt_pkg::t_out_req               o_out_req
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

    logic [lrt_pkg::ADDR_W-1:0] r_host;
    logic [lrt_pkg::ADDR_W-1:0] r_gateway;
    logic [lrt_pkg::ADDR_W-1:0] r_mask;
    logic [TABLE_ENTRIES-1:0]   r_ent_vld;

    lrt_pkg::t_cls              cls;
    logic [IDX_W-1:0]           learn_idx;
    logic [IDX_W-1:0]           rd_idx;
    logic                       accept;
    logic                       s1_move;
    logic                       ram_we;
    logic                       ram_re;
    logic [lrt_pkg::CHAN_W-1:0] ram_rdata;

    logic                        r_s1_vld;
    logic                        r_s1_lookup;
    logic [lrt_pkg::KIND_W-1:0]  r_s1_kind;
    logic                        r_s1_fwd;
    logic [lrt_pkg::CHAN_W-1:0]  r_s1_fwd_ch;
    logic                        r_s1_ent_vld;
    logic                        r_out_vld;
    lrt_pkg::t_out_req           r_out;
    lrt_pkg::t_out_req           n_out;
    logic [lrt_pkg::CHAN_W-1:0]  s1_chan;

    lrt_classify #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_classify (
        .i_req       (i_in_req),
        .i_host      (r_host),
        .i_gateway   (r_gateway),
        .i_mask      (r_mask),
        .o_cls       (cls),
        .o_learn_idx (learn_idx),
        .o_rd_idx    (rd_idx)
    );

    assign s1_move    = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;
    assign ram_we     = accept && cls.learn_en;
    assign ram_re     = accept && cls.lookup;

    lrt_ram #(
        .WIDTH (lrt_pkg::CHAN_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (learn_idx),
        .i_wdata (i_in_req.arrival_channel),
        .i_re    (ram_re),
        .i_raddr (rd_idx),
        .o_rdata (ram_rdata)
    );

    // same-request learn hits the looked-up entry: forward the new channel; no channel makes a lookup invalid
    always_comb begin
        if (r_s1_fwd) begin
            s1_chan = r_s1_fwd_ch;
        end else if (r_s1_ent_vld) begin
            s1_chan = ram_rdata;
        end else begin
            s1_chan = lrt_pkg::CHAN_NONE;
        end
        n_out.route_kind  = r_s1_kind;
        n_out.out_channel = lrt_pkg::CHAN_NONE;
        if (r_s1_lookup) begin
            if (s1_chan == lrt_pkg::CHAN_NONE) begin
                n_out.route_kind = lrt_pkg::KIND_INVALID;
            end else begin
                n_out.out_channel = s1_chan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host    <= '0;
            r_gateway <= '0;
            r_mask    <= lrt_pkg::MASK_RESET;
            r_ent_vld <= '0;
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lrt_pkg::REG_HOST:    r_host    <= i_cfg_wdata;
                    lrt_pkg::REG_GATEWAY: r_gateway <= i_cfg_wdata;
                    lrt_pkg::REG_MASK:    r_mask    <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (ram_we) begin
                r_ent_vld[learn_idx] <= 1'b1;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_lookup  <= cls.lookup;
            r_s1_kind    <= cls.kind;
            r_s1_fwd     <= cls.learn_en && cls.lookup && (learn_idx == rd_idx);
            r_s1_fwd_ch  <= i_in_req.arrival_channel;
            r_s1_ent_vld <= cls.lookup && r_ent_vld[rd_idx];
        end
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;

`ifndef SYNTHESIS
    a_chan_zero_unless_routed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_req.route_kind != lrt_pkg::KIND_LOCAL)
        && (o_out_req.route_kind != lrt_pkg::KIND_GATEWAY)
        |-> o_out_req.out_channel == lrt_pkg::CHAN_NONE)
        else $error("nonzero channel on a non-routed result");

    a_routed_has_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_req.route_kind == lrt_pkg::KIND_LOCAL)
        || (o_out_req.route_kind == lrt_pkg::KIND_GATEWAY))
        |-> o_out_req.out_channel != lrt_pkg::CHAN_NONE)
        else $error("routed result without a channel");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_req.route_kind <= lrt_pkg::KIND_INVALID)
        else $error("route kind out of range");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_move |=> r_s1_vld && $stable(r_s1_kind) && $stable(s1_chan))
        else $error("pending lookup lost while output stalled");
`endif

endmodule

[rtl/lrt_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lrt_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 254
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lrt_classify.sv]
// Request decode: locality tests, learn decision and the early route kind.
// Depends on lrt_pkg.
module lrt_classify #(
    parameter int unsigned TABLE_ENTRIES = 254
) (
    input  lrt_pkg::t_in_req                  i_req,
    input  logic [lrt_pkg::ADDR_W-1:0]        i_host,
    input  logic [lrt_pkg::ADDR_W-1:0]        i_gateway,
    input  logic [lrt_pkg::ADDR_W-1:0]        i_mask,
    output lrt_pkg::t_cls                     o_cls,
    output logic [$clog2(TABLE_ENTRIES)-1:0]  o_learn_idx,
    output logic [$clog2(TABLE_ENTRIES)-1:0]  o_rd_idx
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [lrt_pkg::ID_W:0] ENTRIES = (lrt_pkg::ID_W+1)'(TABLE_ENTRIES);

    logic                     src_local;
    logic                     dst_local;
    logic [lrt_pkg::ID_W-1:0] host_id;
    logic [lrt_pkg::ID_W-1:0] src_id;
    logic [lrt_pkg::ID_W-1:0] rt_id;
    logic [lrt_pkg::ID_W:0]   src_off;
    logic [lrt_pkg::ID_W:0]   rt_off;
    logic                     src_in_tbl;
    logic                     rt_in_tbl;

    always_comb begin
        host_id   = i_host[lrt_pkg::ID_W-1:0];
        src_id    = i_req.source_address[lrt_pkg::ID_W-1:0];
        src_local = (i_req.source_address & i_mask) == (i_host & i_mask);
        dst_local = (i_req.dest_address & i_mask) == (i_host & i_mask);
        rt_id     = dst_local ? i_req.dest_address[lrt_pkg::ID_W-1:0]
                              : i_gateway[lrt_pkg::ID_W-1:0];

        src_off = {1'b0, src_id} - (lrt_pkg::ID_W+1)'(1);
        rt_off  = {1'b0, rt_id} - (lrt_pkg::ID_W+1)'(1);
        src_in_tbl = (src_id != lrt_pkg::ID_NETWORK) && (src_id != lrt_pkg::ID_BROADCAST)
                     && (src_off < ENTRIES);
        rt_in_tbl  = (rt_id != lrt_pkg::ID_NETWORK) && (rt_id != lrt_pkg::ID_BROADCAST)
                     && (rt_off < ENTRIES);

        o_learn_idx    = src_off[IDX_W-1:0];
        o_rd_idx       = rt_off[IDX_W-1:0];
        o_cls.learn_en = !i_req.action && src_local && src_in_tbl;
        o_cls.lookup   = 1'b0;

        if (rt_id == host_id) begin
            o_cls.kind = dst_local ? lrt_pkg::KIND_SELF : lrt_pkg::KIND_GATEWAY_SELF;
        end else if (dst_local && rt_id == lrt_pkg::ID_BROADCAST) begin
            o_cls.kind = lrt_pkg::KIND_BROADCAST;
        end else if (!rt_in_tbl) begin
            o_cls.kind = lrt_pkg::KIND_INVALID;
        end else begin
            o_cls.kind   = dst_local ? lrt_pkg::KIND_LOCAL : lrt_pkg::KIND_GATEWAY;
            o_cls.lookup = 1'b1;
        end
    end

endmodule

[verif/lrt_route_checker.sv]
// Checker for learned_route_table_core: tracks register writes, predicts the route
// of every accepted request and compares it with each accepted result.
// Depends on lrt_pkg.
module lrt_route_checker #(
    parameter int unsigned TABLE_ENTRIES = 254
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lrt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lrt_pkg::ADDR_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  lrt_pkg::t_in_req                i_in_req,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  lrt_pkg::t_out_req               i_out_req,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [lrt_pkg::ADDR_W-1:0] host_addr;
    logic [lrt_pkg::ADDR_W-1:0] gateway_addr;
    logic [lrt_pkg::ADDR_W-1:0] net_mask;
    logic [lrt_pkg::CHAN_W-1:0] chan_table [0:TABLE_ENTRIES-1];
    lrt_pkg::t_out_req          pending_routes [$];
    lrt_pkg::t_out_req          want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic on_local_net(logic [lrt_pkg::ADDR_W-1:0] addr);
        return (addr & net_mask) == (host_addr & net_mask);
    endfunction

    function automatic logic id_has_entry(logic [lrt_pkg::ID_W-1:0] id);
        return id != lrt_pkg::ID_NETWORK && id != lrt_pkg::ID_BROADCAST
               && (int'(id) - 1) < int'(TABLE_ENTRIES);
    endfunction

    // learn first, then classify the destination against the updated table
    function automatic lrt_pkg::t_out_req route_lookup(lrt_pkg::t_in_req req);
        logic [lrt_pkg::ID_W-1:0] host_id;
        logic [lrt_pkg::ID_W-1:0] id;
        lrt_pkg::t_out_req        res;
        host_id = host_addr[lrt_pkg::ID_W-1:0];
        if (req.action == 1'b0 && on_local_net(req.source_address)
                && id_has_entry(req.source_address[lrt_pkg::ID_W-1:0])) begin
            chan_table[int'(req.source_address[lrt_pkg::ID_W-1:0]) - 1] = req.arrival_channel;
        end
        res.out_channel = lrt_pkg::CHAN_NONE;
        if (on_local_net(req.dest_address)) begin
            id = req.dest_address[lrt_pkg::ID_W-1:0];
            if (id == host_id) begin
                res.route_kind = lrt_pkg::KIND_SELF;
                return res;
            end
            if (id == lrt_pkg::ID_BROADCAST) begin
                res.route_kind = lrt_pkg::KIND_BROADCAST;
                return res;
            end
            res.route_kind = lrt_pkg::KIND_LOCAL;
        end else begin
            id = gateway_addr[lrt_pkg::ID_W-1:0];
            if (id == host_id) begin
                res.route_kind = lrt_pkg::KIND_GATEWAY_SELF;
                return res;
            end
            res.route_kind = lrt_pkg::KIND_GATEWAY;
        end
        if (!id_has_entry(id)) begin
            res.route_kind = lrt_pkg::KIND_INVALID;
        end else begin
            res.out_channel = chan_table[int'(id) - 1];
            if (res.out_channel == lrt_pkg::CHAN_NONE) begin
                res.route_kind = lrt_pkg::KIND_INVALID;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            host_addr    = '0;
            gateway_addr = '0;
            net_mask     = lrt_pkg::MASK_RESET;
            for (int k = 0; k < int'(TABLE_ENTRIES); k++) begin
                chan_table[k] = lrt_pkg::CHAN_NONE;
            end
            pending_routes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lrt_pkg::REG_HOST:    host_addr    = i_cfg_wdata;
                    lrt_pkg::REG_GATEWAY: gateway_addr = i_cfg_wdata;
                    lrt_pkg::REG_MASK:    net_mask     = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                pending_routes.push_back(route_lookup(i_in_req));
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_routes.size() == 0) begin
                    $display("%0t: result with no request pending, got kind %0d chan %0d",
                             $time, i_out_req.route_kind, i_out_req.out_channel);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = pending_routes.pop_front();
                    if (want.route_kind !== i_out_req.route_kind) begin
                        $display("%0t: route_kind mismatch, expected %0d, got %0d",
                                 $time, want.route_kind, i_out_req.route_kind);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (want.out_channel !== i_out_req.out_channel) begin
                        $display("%0t: out_channel mismatch, expected %0d, got %0d",
                                 $time, want.out_channel, i_out_req.out_channel);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = pending_routes.size();
    end

endmodule

[verif/tb_learned_route_table_core.sv]
// Testbench top for learned_route_table_core: directed and random requests across
// several register settings, random idling on both sides, verdict from the checker.
// Depends on lrt_pkg, learned_route_table_core, lrt_route_checker.
module tb_learned_route_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_ENTRIES   = 254;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          RANDOM_PHASES   = 8;
    localparam int          REQS_PER_PHASE  = 205;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [lrt_pkg::CFG_IDX_W-1:0] i_cfg_idx   = lrt_pkg::REG_HOST;
    logic [lrt_pkg::ADDR_W-1:0]    i_cfg_wdata = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_stall;
    lrt_pkg::t_in_req              i_in_req    = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    lrt_pkg::t_out_req             o_out_req;

    int                            fail_count;
    int                            pending;
    int                            cycle_count = 0;
    logic                          calm        = 1'b0;

    logic [lrt_pkg::ADDR_W-1:0]    cur_host;
    logic [lrt_pkg::ADDR_W-1:0]    cur_gw;
    logic [lrt_pkg::ADDR_W-1:0]    cur_mask;
    logic [lrt_pkg::ID_W-1:0]      id_pool [0:7];

    learned_route_table_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_req  (o_out_req)
    );

    lrt_route_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_req   (o_out_req),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 13);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // address on the current local network carrying the given id where the mask allows
    function automatic logic [lrt_pkg::ADDR_W-1:0] net_addr(logic [lrt_pkg::ID_W-1:0] id);
        logic [lrt_pkg::ADDR_W-1:0] r;
        r = $urandom;
        r[lrt_pkg::ID_W-1:0] = id;
        return (cur_host & cur_mask) | (r & ~cur_mask);
    endfunction

    function automatic logic [lrt_pkg::ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 85) begin
            return id_pool[$urandom_range(0, 7)];
        end
        return (lrt_pkg::ID_W)'($urandom);
    endfunction

    task automatic send_req(input logic act, input logic [lrt_pkg::CHAN_W-1:0] ch,
                            input logic [lrt_pkg::ADDR_W-1:0] src,
                            input logic [lrt_pkg::ADDR_W-1:0] dst);
        lrt_pkg::t_in_req req;
        req.action          = act;
        req.arrival_channel = ch;
        req.source_address  = src;
        req.dest_address    = dst;
        while (!calm && $urandom_range(0, 99) < 13) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(input logic [lrt_pkg::ADDR_W-1:0] host,
                              input logic [lrt_pkg::ADDR_W-1:0] gw,
                              input logic [lrt_pkg::ADDR_W-1:0] mask);
        drain();
        cur_host = host;
        cur_gw   = gw;
        cur_mask = mask;
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= lrt_pkg::REG_HOST;
        i_cfg_wdata <= host;
        @(negedge i_clk);
        i_cfg_idx   <= lrt_pkg::REG_GATEWAY;
        i_cfg_wdata <= gw;
        @(negedge i_clk);
        i_cfg_idx   <= lrt_pkg::REG_MASK;
        i_cfg_wdata <= mask;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        id_pool[0] = host[lrt_pkg::ID_W-1:0];
        id_pool[1] = lrt_pkg::ID_NETWORK;
        id_pool[2] = lrt_pkg::ID_BROADCAST;
        id_pool[3] = gw[lrt_pkg::ID_W-1:0];
        id_pool[4] = 8'd1;
        id_pool[5] = 8'd254;
        id_pool[6] = (lrt_pkg::ID_W)'($urandom);
        id_pool[7] = (lrt_pkg::ID_W)'($urandom);
        @(negedge i_clk);
    endtask

    task automatic random_req();
        logic [lrt_pkg::ADDR_W-1:0] dst;
        if ($urandom_range(0, 99) < 80) begin
            if ($urandom_range(0, 99) < 60) begin
                dst = net_addr(pick_id());
            end else begin
                dst = $urandom;
            end
            send_req($urandom_range(0, 3) == 0, (lrt_pkg::CHAN_W)'($urandom),
                     net_addr(pick_id()), dst);
        end else begin
            send_req(1'($urandom), (lrt_pkg::CHAN_W)'($urandom), $urandom, $urandom);
        end
    endtask

    initial begin
        logic [lrt_pkg::ADDR_W-1:0] mask;
        logic [lrt_pkg::ADDR_W-1:0] host;
        logic [lrt_pkg::ADDR_W-1:0] gw;
        int                         pick;

        cur_host = '0;
        cur_gw   = '0;
        cur_mask = lrt_pkg::MASK_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults: host id 0, gateway id 0, empty table
        send_req(1'b1, 4'h0, 32'h0000_0000, 32'h0000_0000);
        send_req(1'b1, 4'h0, 32'h0000_0000, 32'h0000_00FF);
        send_req(1'b1, 4'h0, 32'h0000_0000, 32'h0000_0005);
        send_req(1'b1, 4'h0, 32'h0000_0000, 32'h0A00_0001);

        set_config(32'hC0A8_010A, 32'hC0A8_0101, 32'hFFFF_FF00);
        send_req(1'b1, 4'h3, 32'hC0A8_0101, 32'h0808_0808);
        send_req(1'b0, 4'h3, 32'hC0A8_0101, 32'h0808_0808);
        send_req(1'b1, 4'h0, 32'h0A00_0001, 32'hC0A8_0101);
        send_req(1'b1, 4'h0, 32'h0A00_0001, 32'hC0A8_010A);
        send_req(1'b1, 4'h0, 32'h0A00_0001, 32'hC0A8_01FF);
        send_req(1'b1, 4'h0, 32'h0A00_0001, 32'hC0A8_0100);
        send_req(1'b0, 4'h5, 32'hC0A8_0100, 32'hC0A8_0100);
        send_req(1'b0, 4'h7, 32'hC0A8_01FF, 32'hC0A8_01FF);
        send_req(1'b0, 4'h4, 32'h0A00_0002, 32'hC0A8_0102);
        send_req(1'b1, 4'h9, 32'hC0A8_0102, 32'hC0A8_0102);
        send_req(1'b0, 4'hF, 32'hC0A8_0102, 32'hC0A8_0102);
        send_req(1'b0, 4'h0, 32'hC0A8_0102, 32'hC0A8_0102);
        send_req(1'b0, 4'hF, 32'hC0A8_01FE, 32'hC0A8_01FE);
        send_req(1'b0, 4'h1, 32'hC0A8_01FE, 32'hFFFF_FFFF);
        send_req(1'b0, 4'h6, 32'hC0A8_010A, 32'hC0A8_010A);
        send_req(1'b0, 4'h0, 32'h0000_0000, 32'h0000_0000);
        send_req(1'b1, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // gateway with the host's own id, then reserved gateway ids
        set_config(32'hC0A8_010A, 32'h0A00_000A, 32'hFFFF_FF00);
        send_req(1'b1, 4'h0, 32'h0000_0000, 32'h0808_0808);
        set_config(32'hC0A8_010A, 32'h0A00_0000, 32'hFFFF_FF00);
        send_req(1'b1, 4'h0, 32'h0000_0000, 32'h0808_0808);
        set_config(32'hC0A8_010A, 32'h0A00_00FF, 32'h0000_0000);
        send_req(1'b1, 4'h0, 32'h0000_0000, 32'h1234_5601);
        set_config(32'hC0A8_010A, 32'h0A00_00FF, 32'hFFFF_FFFF);
        send_req(1'b1, 4'h0, 32'h0000_0000, 32'hC0A8_010B);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0, 5, 7: mask = 32'hFFFF_FF00;
                1:       mask = 32'hFFFF_FFF0;
                2:       mask = 32'hFFFF_0000;
                3:       mask = 32'h0000_0000;
                4:       mask = 32'hFFFF_FFFF;
                default: mask = $urandom;
            endcase
            host = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                gw = (host & mask) | ($urandom & ~mask);
            end else if (pick < 70) begin
                gw = {~host[lrt_pkg::ADDR_W-1:lrt_pkg::ID_W], host[lrt_pkg::ID_W-1:0]};
            end else begin
                gw = $urandom;
            end
            set_config(host, gw, mask);
            calm = (ph == 5);
            for (int n = 0; n < REQS_PER_PHASE; n++) begin
                random_req();
            end
            calm = 1'b0;
        end

        drain();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[learned_route_table_core.f]
rtl/lrt_pkg.sv
rtl/lrt_ram.sv
rtl/lrt_classify.sv
rtl/learned_route_table_core.sv
verif/lrt_route_checker.sv
verif/tb_learned_route_table_core.sv
